/* rtl/pixrop_pkg.sv */
// ----------------------------------------------------------------------------
// pixrop_pkg
// Shared types and constants of the pixel raster operation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pixrop_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned OpW   = 3;
  localparam int unsigned IdxW  = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 3'd0,
    OP_COPY  = 3'd1,
    OP_BLEND = 3'd2,
    OP_ADD   = 3'd3,
    OP_SUB   = 3'd4
  } op_e;

  typedef enum logic [IdxW-1:0] {
    REG_OPERATION = 3'd0,
    REG_SRC_RED   = 3'd1,
    REG_SRC_GREEN = 3'd2,
    REG_SRC_BLUE  = 3'd3,
    REG_SRC_ALPHA = 3'd4,
    REG_HAS_ALPHA = 3'd5
  } reg_idx_e;

  // Operation is held raw: unused codes must pass pixels through.
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [ChanW-1:0] src_red;
    logic [ChanW-1:0] src_green;
    logic [ChanW-1:0] src_blue;
    logic [ChanW-1:0] src_alpha;
    logic             has_alpha;
  } cfg_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/pixrop_cfg.sv */
// ----------------------------------------------------------------------------
// pixrop_cfg
// Configuration register file: operation, source color and alpha mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pixrop_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pixrop_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [pixrop_pkg::ChanW-1:0] cfg_data_i,
  output pixrop_pkg::cfg_t               cfg_o
);
  import pixrop_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OPERATION: cfg_d.operation = cfg_data_i[OpW-1:0];
        REG_SRC_RED:   cfg_d.src_red   = cfg_data_i;
        REG_SRC_GREEN: cfg_d.src_green = cfg_data_i;
        REG_SRC_BLUE:  cfg_d.src_blue  = cfg_data_i;
        REG_SRC_ALPHA: cfg_d.src_alpha = cfg_data_i;
        REG_HAS_ALPHA: cfg_d.has_alpha = cfg_data_i[0];
        default:       cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operation <= OP_BLEND;
      cfg_q.src_red   <= '0;
      cfg_q.src_green <= '0;
      cfg_q.src_blue  <= '0;
      cfg_q.src_alpha <= ChanMax;
      cfg_q.has_alpha <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/pixrop_chan.sv */
// ----------------------------------------------------------------------------
// pixrop_chan
// Three-stage datapath of one color channel: capture, multiply/saturate,
// sum and operation select.
// ----------------------------------------------------------------------------
`default_nettype none

module pixrop_chan (
  input  wire logic                         clk_i,
  input  wire pixrop_pkg::pipe_ctrl_t       ctrl_i,
  input  wire logic [pixrop_pkg::OpW-1:0]   op_i,
  input  wire logic [pixrop_pkg::ChanW-1:0] dst_i,
  input  wire logic [pixrop_pkg::ChanW-1:0] src_i,
  input  wire logic [pixrop_pkg::ChanW-1:0] alpha_i,
  output logic      [pixrop_pkg::ChanW-1:0] new_o
);
  import pixrop_pkg::*;

  localparam int unsigned ProdW = 2 * ChanW;

  logic [ChanW-1:0] dst1_q;
  logic [ChanW-1:0] dst2_q;
  logic [ProdW-1:0] mul_d_q, mul_d_d;
  logic [ProdW-1:0] mul_s_q, mul_s_d;
  logic [ChanW:0]   add_q, add_d;
  logic [ChanW-1:0] sub_q, sub_d;
  logic [ChanW-1:0] new_q, new_d;
  logic [ProdW-1:0] blend_sum;
  logic [ChanW-1:0] inv_alpha;

  // Stage 2: products and saturating terms
  always_comb begin
    inv_alpha = ChanMax - alpha_i;
    mul_d_d   = ProdW'(dst1_q) * ProdW'(inv_alpha);
    mul_s_d   = ProdW'(src_i) * ProdW'(alpha_i);
    add_d     = {1'b0, dst1_q} + {1'b0, src_i};
    sub_d     = (dst1_q > src_i) ? (dst1_q - src_i) : '0;
  end

  // Stage 3: sum of products fits 16 bits (255*255 at most)
  always_comb begin
    blend_sum = mul_d_q + mul_s_q;
    case (op_i)
      OP_CLEAR: new_d = '0;
      OP_COPY:  new_d = src_i;
      OP_BLEND: new_d = (alpha_i == ChanMax) ? src_i : blend_sum[ProdW-1:ChanW];
      OP_ADD:   new_d = add_q[ChanW] ? ChanMax : add_q[ChanW-1:0];
      OP_SUB:   new_d = sub_q;
      default:  new_d = dst2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      dst1_q <= dst_i;
    end
    if (ctrl_i.s2_en) begin
      dst2_q  <= dst1_q;
      mul_d_q <= mul_d_d;
      mul_s_q <= mul_s_d;
      add_q   <= add_d;
      sub_q   <= sub_d;
    end
    if (ctrl_i.s3_en) begin
      new_q <= new_d;
    end
  end

  assign new_o = new_q;

endmodule

`default_nettype wire

/* rtl/pixel_raster_operation_unit.sv */
// ----------------------------------------------------------------------------
// pixel_raster_operation_unit
// Raster operation on a stream of RGBA pixels against a configured source
// color: clear, copy, alpha blend, saturating add and subtract.
//
// Usage:
//   Pixels enter on the s_axis channel, one per transaction, and leave on
//   m_axis in the same order, one result per pixel. Each pixel walks three
//   register stages (capture, multiply, sum/select); the last stage is the
//   output register, which drives m_axis_tvalid. Throughput is one pixel per
//   clock while the receiver takes results. When the receiver stalls with a
//   result pending, all stages hold and s_axis_tready drops the same cycle;
//   nothing is lost or repeated. Configuration registers are written through
//   cfg_we_i/cfg_idx_i/cfg_data_i, one per clock; the user must write them only
//   while the pipeline is empty, as the block itself does not enforce it.
//   Reset empties the pipeline and loads operation = blend, source color
//   black, source alpha opaque, alpha channel present.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_raster_operation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // input pixels
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // dst_red, dst_green, dst_blue, dst_alpha
  // output pixels
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // new_red, new_green, new_blue, new_alpha
);
  import pixrop_pkg::*;

  cfg_t       cfg;
  pipe_ctrl_t ctrl;
  logic       advance;
  logic       v1_q, v2_q, v3_q;
  logic [ChanW-1:0] a1_q, a2_q, na_q, na_d;
  logic [ChanW-1:0] min_a;
  logic [ChanW-1:0] new_red, new_green, new_blue;

  pixrop_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Whole pipeline moves unless a finished result waits.
  assign advance       = !v3_q || m_axis_tready;
  assign ctrl.s1_en    = advance;
  assign ctrl.s2_en    = advance;
  assign ctrl.s3_en    = advance;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  pixrop_chan u_red (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .op_i    (cfg.operation),
    .dst_i   (s_axis_tdata[7:0]),
    .src_i   (cfg.src_red),
    .alpha_i (cfg.src_alpha),
    .new_o   (new_red)
  );

  pixrop_chan u_green (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .op_i    (cfg.operation),
    .dst_i   (s_axis_tdata[15:8]),
    .src_i   (cfg.src_green),
    .alpha_i (cfg.src_alpha),
    .new_o   (new_green)
  );

  pixrop_chan u_blue (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .op_i    (cfg.operation),
    .dst_i   (s_axis_tdata[23:16]),
    .src_i   (cfg.src_blue),
    .alpha_i (cfg.src_alpha),
    .new_o   (new_blue)
  );

  // Alpha lane: no arithmetic until the last stage.
  always_comb begin
    min_a = (a2_q < cfg.src_alpha) ? a2_q : cfg.src_alpha;
    case (cfg.operation)
      OP_CLEAR: na_d = '0;
      OP_COPY:  na_d = cfg.src_alpha;
      OP_BLEND: na_d = (cfg.src_alpha == ChanMax) ? ChanMax : a2_q;
      OP_ADD:   na_d = min_a;
      OP_SUB:   na_d = min_a;
      default:  na_d = a2_q;
    endcase
    if (!cfg.has_alpha) begin
      na_d = a2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a1_q <= s_axis_tdata[31:24];
      a2_q <= a1_q;
      na_q <= na_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {na_q, new_blue, new_green, new_red};

  // An accepted pixel is in stage 1 next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted pixel missing from stage 1");

  // A stall freezes every valid bit.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(v1_q) && $stable(v2_q) && v3_q)
    else $error("pipeline moved during stall");

  // Stage 2 content reaches the output when the pipe advances.
  a_v2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && v2_q |=> m_axis_tvalid)
    else $error("pixel dropped between stage 2 and output");

  // An empty output register never blocks the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

`default_nettype wire
